FILE: hdl/triangle_box_overlap_test_top_assert.svh
// assertion macros for the triangle/box overlap block
`ifndef TRIANGLE_BOX_OVERLAP_TEST_TOP_ASSERT_SVH
`define TRIANGLE_BOX_OVERLAP_TEST_TOP_ASSERT_SVH

// property checked at every clock edge outside reset
`define TBOT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle, consequent in the next
`define TBOT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/tbot_pkg.sv
package tbot_pkg;

  // default coordinate width
  localparam int unsigned COORD_WIDTH_DEFAULT = 16;

  // vertex fields in one input transfer
  localparam int unsigned NUM_IN_FIELDS = 9;

  // output stream data width (one flag, padded to a byte)
  localparam int unsigned OUT_DATA_W = 8;

  // register stages from input transfer to output register
  localparam int unsigned NUM_STAGES = 7;

  // stage whose registers hold the three separation flags
  localparam int unsigned SEP_STAGE = NUM_STAGES - 2;

  // configuration register index
  localparam int unsigned CFG_ADDR_W = 3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BOX_MIN_X,
    REG_BOX_MIN_Y,
    REG_BOX_MIN_Z,
    REG_BOX_MAX_X,
    REG_BOX_MAX_Y,
    REG_BOX_MAX_Z
  } cfg_reg_e;

  // per-stage load enables from the pipeline control
  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
  } stage_ctl_t;

endpackage

FILE: hdl/tbot_cfg.sv
module tbot_cfg
  import tbot_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0]         cfg_addr_i,
  input  logic [COORD_WIDTH-1:0]        cfg_data_i,
  output logic signed [COORD_WIDTH-1:0] box_min_o [3],
  output logic signed [COORD_WIDTH-1:0] box_max_o [3]
);

  logic signed [COORD_WIDTH-1:0] box_min_q [3];
  logic signed [COORD_WIDTH-1:0] box_max_q [3];

  // writes are always taken
  assign cfg_ready_o = 1'b1;

  // box bound registers, writes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        box_min_q[k] <= '0;
        box_max_q[k] <= '0;
      end
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_BOX_MIN_X: box_min_q[0] <= cfg_data_i;
        REG_BOX_MIN_Y: box_min_q[1] <= cfg_data_i;
        REG_BOX_MIN_Z: box_min_q[2] <= cfg_data_i;
        REG_BOX_MAX_X: box_max_q[0] <= cfg_data_i;
        REG_BOX_MAX_Y: box_max_q[1] <= cfg_data_i;
        REG_BOX_MAX_Z: box_max_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign box_min_o = box_min_q;
  assign box_max_o = box_max_q;

endmodule

FILE: hdl/tbot_face.sv
module tbot_face
  import tbot_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
  input  logic                          clk_i,
  input  stage_ctl_t                    ctl_i,
  input  logic signed [COORD_WIDTH-1:0] vtx_i [3][3],
  input  logic signed [COORD_WIDTH-1:0] box_min_i [3],
  input  logic signed [COORD_WIDTH-1:0] box_max_i [3],
  output logic                          sep_o
);

  // edge and offset width, normal product width, normal width
  localparam int unsigned FW   = COORD_WIDTH + 1;
  localparam int unsigned NPW  = 2 * FW;
  localparam int unsigned NW   = NPW + 1;
  // normal split into an unsigned low part and a signed high part
  localparam int unsigned NL   = COORD_WIDTH + 2;
  localparam int unsigned NH   = NW - NL;
  localparam int unsigned PLW  = NL + 1 + FW;
  localparam int unsigned PHW  = NH + FW;
  // full term width and sum width
  localparam int unsigned TW   = NW + FW;
  localparam int unsigned SUMW = TW + 2;

  logic signed [FW-1:0]  f1_q [3];
  logic signed [FW-1:0]  f2_q [3];
  logic signed [FW-1:0]  dmin1_q [3], dmax1_q [3];
  logic signed [FW-1:0]  dmin2_q [3], dmax2_q [3];
  logic signed [FW-1:0]  dmin3_q [3], dmax3_q [3];
  logic [2:0]            flip1_q, flip2_q, flip3_q;
  logic signed [NPW-1:0] npa_q [3], npb_q [3];
  logic signed [NW-1:0]  n_q [3];
  logic signed [PLW-1:0] plo_min_q [3], plo_max_q [3];
  logic signed [PHW-1:0] phi_min_q [3], phi_max_q [3];
  logic [2:0]            sel_q;
  logic signed [TW-1:0]  tlo_q [3], thi_q [3];
  logic signed [SUMW-1:0] smin, smax;
  logic                  sep_q;

  for (genvar gk = 0; gk < 3; gk++) begin : g_comp
    localparam int K1 = (gk + 1) % 3;
    localparam int K2 = (gk + 2) % 3;

    logic [NL-1:0]         n_lo;
    logic signed [NH-1:0]  n_hi;
    logic signed [TW-1:0]  full_min, full_max;

    assign n_lo = n_q[gk][NL-1:0];
    assign n_hi = $signed(n_q[gk][NW-1:NL]);

    assign full_min = (TW'(phi_min_q[gk]) <<< NL) + TW'(plo_min_q[gk]);
    assign full_max = (TW'(phi_max_q[gk]) <<< NL) + TW'(plo_max_q[gk]);

    // edges from the first vertex, box corners relative to it
    always_ff @(posedge clk_i) begin
      if (ctl_i.en[0]) begin
        f1_q[gk]    <= FW'(vtx_i[1][gk]) - FW'(vtx_i[0][gk]);
        f2_q[gk]    <= FW'(vtx_i[2][gk]) - FW'(vtx_i[0][gk]);
        dmin1_q[gk] <= FW'(box_min_i[gk]) - FW'(vtx_i[0][gk]);
        dmax1_q[gk] <= FW'(box_max_i[gk]) - FW'(vtx_i[0][gk]);
        flip1_q[gk] <= box_min_i[gk] > box_max_i[gk];
      end
    end

    // cross product terms
    always_ff @(posedge clk_i) begin
      if (ctl_i.en[1]) begin
        npa_q[gk]   <= NPW'(f1_q[K1]) * NPW'(f2_q[K2]);
        npb_q[gk]   <= NPW'(f1_q[K2]) * NPW'(f2_q[K1]);
        dmin2_q[gk] <= dmin1_q[gk];
        dmax2_q[gk] <= dmax1_q[gk];
        flip2_q[gk] <= flip1_q[gk];
      end
    end

    // face normal component
    always_ff @(posedge clk_i) begin
      if (ctl_i.en[2]) begin
        n_q[gk]     <= NW'(npa_q[gk]) - NW'(npb_q[gk]);
        dmin3_q[gk] <= dmin2_q[gk];
        dmax3_q[gk] <= dmax2_q[gk];
        flip3_q[gk] <= flip2_q[gk];
      end
    end

    // partial products of normal times corner offset
    always_ff @(posedge clk_i) begin
      if (ctl_i.en[3]) begin
        plo_min_q[gk] <= PLW'($signed({1'b0, n_lo})) * PLW'(dmin3_q[gk]);
        plo_max_q[gk] <= PLW'($signed({1'b0, n_lo})) * PLW'(dmax3_q[gk]);
        phi_min_q[gk] <= PHW'(n_hi) * PHW'(dmin3_q[gk]);
        phi_max_q[gk] <= PHW'(n_hi) * PHW'(dmax3_q[gk]);
        // lower bound term comes from the min corner when sign and order agree
        sel_q[gk]     <= !n_q[gk][NW-1] ^ flip3_q[gk];
      end
    end

    // assemble full terms and order them
    always_ff @(posedge clk_i) begin
      if (ctl_i.en[4]) begin
        tlo_q[gk] <= sel_q[gk] ? full_min : full_max;
        thi_q[gk] <= sel_q[gk] ? full_max : full_min;
      end
    end
  end

  // box extent along the normal, relative to the triangle plane
  assign smin = SUMW'(tlo_q[0]) + SUMW'(tlo_q[1]) + SUMW'(tlo_q[2]);
  assign smax = SUMW'(thi_q[0]) + SUMW'(thi_q[1]) + SUMW'(thi_q[2]);

  // plane misses the box when the extent stays on one side
  always_ff @(posedge clk_i) begin
    if (ctl_i.en[5]) begin
      sep_q <= (!smin[SUMW-1] && (smin != '0)) || smax[SUMW-1];
    end
  end

  assign sep_o = sep_q;

endmodule

FILE: hdl/tbot_edge.sv
module tbot_edge
  import tbot_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
  input  logic                          clk_i,
  input  stage_ctl_t                    ctl_i,
  input  logic signed [COORD_WIDTH-1:0] vtx_i [3][3],
  input  logic signed [COORD_WIDTH-1:0] box_min_i [3],
  input  logic signed [COORD_WIDTH-1:0] box_max_i [3],
  output logic                          sep_o
);

  // edge width, product width, projection width
  localparam int unsigned EW = COORD_WIDTH + 1;
  localparam int unsigned PW = EW + COORD_WIDTH;
  localparam int unsigned SW = PW + 1;

  logic signed [EW-1:0]          e_q [3][3];
  logic signed [COORD_WIDTH-1:0] v_q [3][3];
  logic [8:0]                    ax_sep;
  logic                          sep5_q, sep6_q;

  // edges v(i) - v(i+1)
  always_ff @(posedge clk_i) begin
    if (ctl_i.en[0]) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          e_q[i][k] <= EW'(vtx_i[i][k]) - EW'(vtx_i[(i == 2) ? 0 : i + 1][k]);
          v_q[i][k] <= vtx_i[i][k];
        end
      end
    end
  end

  for (genvar gi = 0; gi < 3; gi++) begin : g_edge
    // the far vertex; both edge endpoints project to the same value
    localparam int VC = (gi + 2) % 3;

    for (genvar gj = 0; gj < 3; gj++) begin : g_axis
      localparam int K1 = (gj + 1) % 3;
      localparam int K2 = (gj + 2) % 3;

      logic signed [PW-1:0] ta1_q, ta2_q, tc1_q, tc2_q;
      logic signed [PW-1:0] b1n_q, b1x_q, b2n_q, b2x_q;
      logic signed [SW-1:0] pa_q, pc_q;
      logic signed [PW-1:0] m1lo_q, m1hi_q, m2lo_q, m2hi_q;
      logic signed [SW-1:0] blo, bhi;
      logic                 sep_q;

      // axis is (edge x unit axis); projection = e[K2]*p[K1] - e[K1]*p[K2]
      always_ff @(posedge clk_i) begin
        if (ctl_i.en[1]) begin
          ta1_q <= PW'(e_q[gi][K2]) * PW'(v_q[gi][K1]);
          ta2_q <= PW'(e_q[gi][K1]) * PW'(v_q[gi][K2]);
          tc1_q <= PW'(e_q[gi][K2]) * PW'(v_q[VC][K1]);
          tc2_q <= PW'(e_q[gi][K1]) * PW'(v_q[VC][K2]);
          b1n_q <= PW'(e_q[gi][K2]) * PW'(box_min_i[K1]);
          b1x_q <= PW'(e_q[gi][K2]) * PW'(box_max_i[K1]);
          b2n_q <= PW'(e_q[gi][K1]) * PW'(box_min_i[K2]);
          b2x_q <= PW'(e_q[gi][K1]) * PW'(box_max_i[K2]);
        end
      end

      // triangle projections and per-term box extremes
      always_ff @(posedge clk_i) begin
        if (ctl_i.en[2]) begin
          pa_q   <= SW'(ta1_q) - SW'(ta2_q);
          pc_q   <= SW'(tc1_q) - SW'(tc2_q);
          m1lo_q <= (b1n_q < b1x_q) ? b1n_q : b1x_q;
          m1hi_q <= (b1n_q < b1x_q) ? b1x_q : b1n_q;
          m2lo_q <= (b2n_q < b2x_q) ? b2n_q : b2x_q;
          m2hi_q <= (b2n_q < b2x_q) ? b2x_q : b2n_q;
        end
      end

      assign blo = SW'(m1lo_q) - SW'(m2hi_q);
      assign bhi = SW'(m1hi_q) - SW'(m2lo_q);

      // separated when both projections lie beyond one end of the box span
      always_ff @(posedge clk_i) begin
        if (ctl_i.en[3]) begin
          sep_q <= ((bhi < pa_q) && (bhi < pc_q)) || ((pa_q < blo) && (pc_q < blo));
        end
      end

      assign ax_sep[gi * 3 + gj] = sep_q;
    end
  end

  // merge the nine axes and align with the face path
  always_ff @(posedge clk_i) begin
    if (ctl_i.en[4]) begin
      sep5_q <= |ax_sep;
    end
    if (ctl_i.en[5]) begin
      sep6_q <= sep5_q;
    end
  end

  assign sep_o = sep6_q;

endmodule

FILE: hdl/triangle_box_overlap_test_top.sv
// Triangle versus axis-aligned box overlap, separating axis test on 13 axes (three box
// axes, the face normal, nine cross products of edge and axis), exact integer arithmetic,
// touching counts as overlap. The box bounds sit in six registers written over the
// configuration channel (index 0..2 min x/y/z, 3..5 max x/y/z, other indexes ignored);
// the user must write them only while no triangle is in flight; the block does not
// enforce it. Each input transfer carries one triangle and yields one output transfer
// with the overlap flag. The datapath is a seven-stage pipeline of registered multiplier
// and add/compare steps, so a new triangle is taken every cycle unless the output backs
// up; stages with a free slot keep filling while a finished result waits on the output.
module triangle_box_overlap_test_top
  import tbot_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [COORD_WIDTH-1:0] cfg_data_i,
  // triangle stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, zero fill
  input  logic [((NUM_IN_FIELDS * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // overlaps, zero fill
  output logic [OUT_DATA_W-1:0]  m_axis_tdata
);

  logic signed [COORD_WIDTH-1:0] vtx [3][3];
  logic signed [COORD_WIDTH-1:0] box_min [3];
  logic signed [COORD_WIDTH-1:0] box_max [3];
  logic signed [COORD_WIDTH-1:0] lo, hi;

  logic [NUM_STAGES-1:0] vld_q, vin, rdy;
  stage_ctl_t            ctl;
  logic                  box_sep_d;
  logic [SEP_STAGE:0]    box_sep_q;
  logic                  edge_sep, face_sep;
  logic                  ovl_q;

  // unpack the vertex fields
  for (genvar gi = 0; gi < 3; gi++) begin : g_vtx
    for (genvar gk = 0; gk < 3; gk++) begin : g_crd
      assign vtx[gi][gk] = s_axis_tdata[(gi * 3 + gk) * COORD_WIDTH +: COORD_WIDTH];
    end
  end

  tbot_cfg #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .box_min_o  (box_min),
    .box_max_o  (box_max)
  );

  // stage handshake, a stage takes data when empty or when its successor moves
  always_comb begin
    vin[0] = s_axis_tvalid;
    for (int k = 1; k < NUM_STAGES; k++) begin
      vin[k] = vld_q[k-1];
    end
    rdy[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || m_axis_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign ctl.en = vin & rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vin[k];
        end
      end
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[NUM_STAGES-1];

  // box axes: triangle extent per coordinate against the bounds
  always_comb begin
    box_sep_d = 1'b0;
    lo = '0;
    hi = '0;
    for (int k = 0; k < 3; k++) begin
      lo = vtx[0][k];
      hi = vtx[0][k];
      for (int i = 1; i < 3; i++) begin
        if (vtx[i][k] < lo) begin
          lo = vtx[i][k];
        end
        if (vtx[i][k] > hi) begin
          hi = vtx[i][k];
        end
      end
      if ((hi < box_min[k]) || (lo > box_max[k])) begin
        box_sep_d = 1'b1;
      end
    end
  end

  // box axis flag travels alongside the other paths
  always_ff @(posedge clk_i) begin
    if (ctl.en[0]) begin
      box_sep_q[0] <= box_sep_d;
    end
    for (int k = 1; k <= SEP_STAGE; k++) begin
      if (ctl.en[k]) begin
        box_sep_q[k] <= box_sep_q[k-1];
      end
    end
  end

  tbot_face #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_face (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .vtx_i    (vtx),
    .box_min_i(box_min),
    .box_max_i(box_max),
    .sep_o    (face_sep)
  );

  tbot_edge #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_edge (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .vtx_i    (vtx),
    .box_min_i(box_min),
    .box_max_i(box_max),
    .sep_o    (edge_sep)
  );

  // output register
  always_ff @(posedge clk_i) begin
    if (ctl.en[NUM_STAGES-1]) begin
      ovl_q <= !(box_sep_q[SEP_STAGE] || edge_sep || face_sep);
    end
  end

  assign m_axis_tdata = {{(OUT_DATA_W - 1){1'b0}}, ovl_q};

endmodule

FILE: hdl/tbot_chk.sv
`include "triangle_box_overlap_test_top_assert.svh"

module tbot_chk
  import tbot_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // a held result keeps its value
  `TBOT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // the input side only stalls when the whole pipeline backs up from the output
  `TBOT_ASSERT(a_stall_src, clk_i, rst_ni, !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready), "input stalled without output backpressure")

  // a result after an empty output slot has a matching earlier input transfer
  `TBOT_ASSERT(a_latency, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, NUM_STAGES), "result without matching input transfer")

  // nothing comes out right after reset
  `TBOT_ASSERT(a_reset_empty, clk_i, rst_ni, $rose(rst_ni) |-> !m_axis_tvalid, "result valid right after reset")

endmodule

bind triangle_box_overlap_test_top tbot_chk u_tbot_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
